@@ rtl/signed_decimal_ascii_formatter_core_macros.svh @@
// Assertion helpers for the formatter RTL, used by sdaf_back.
`ifndef SIGNED_DECIMAL_ASCII_FORMATTER_CORE_MACROS_SVH
`define SIGNED_DECIMAL_ASCII_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define SDAF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdaf check failed");

// Next-cycle implication, quiet during reset.
`define SDAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdaf sequence check failed");

`endif

@@ rtl/sdaf_pkg.sv @@
`default_nettype none
package sdaf_pkg;

  localparam int unsigned InWidth    = 16;
  localparam int unsigned MagWidth   = 14;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [MagWidth-1:0]  MagLimit   = 14'd9999;
  localparam logic [MagWidth-1:0]  ScaleThou  = 14'd1000;
  localparam logic [MagWidth-1:0]  ScaleHund  = 14'd100;
  localparam logic [MagWidth-1:0]  ScaleTens  = 14'd10;

  localparam logic [ByteWidth-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteWidth-1:0] AsciiMinus = 8'h2D;
  localparam logic [ByteWidth-1:0] AsciiCr    = 8'h0D;

  // Sign flag and saturated magnitude of one input item.
  typedef struct packed {
    logic                neg;
    logic [MagWidth-1:0] mag;
  } entry_t;

  // Position within the six-byte output run.
  typedef enum logic [2:0] {
    POS_SIGN,
    POS_THOU,
    POS_HUND,
    POS_TENS,
    POS_UNITS,
    POS_CR
  } pos_t;

  typedef struct packed {
    logic [3:0]          digit;
    logic [MagWidth-1:0] sub;
  } digit_t;

  // Largest k in 0..9 with k*scale <= rem; rem must stay below 10*scale.
  function automatic digit_t digit_step(input logic [MagWidth-1:0] rem,
                                        input logic [MagWidth-1:0] scale);
    digit_t r;
    logic [MagWidth-1:0] thresh;
    r.digit = 4'd0;
    r.sub   = '0;
    for (int k = 1; k <= 9; k++) begin
      thresh = MagWidth'(k * scale);
      if (rem >= thresh) begin
        r.digit = 4'(k);
        r.sub   = thresh;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/signed_decimal_ascii_formatter_core.sv @@
`default_nettype none
// Signed decimal text formatter: each signed 16-bit value taken on the s_ side leaves
// the m_ side as six ASCII bytes, one per beat: a sign byte ('-' when negative, else
// '0'), the thousands, hundreds, tens and units digits of the magnitude (saturated at
// 9999, so -32768 reads "-9999"), then a carriage return flagged with m_tlast. The
// output port moves one byte per cycle while m_tready is high; a value passes the
// input register, the queue and the output register before its sign byte appears.
// A queue of QUEUE_DEPTH entries between the input classifier and the digit sequencer
// keeps s_tready high while the output stalls, until it and the input register fill.
// No reset-time initialization pass is needed.
module signed_decimal_ascii_formatter_core #(
  parameter int unsigned QUEUE_DEPTH = sdaf_pkg::QueueDepth
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic signed [sdaf_pkg::InWidth-1:0] s_tdata,   // [15:0] signed_value
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [sdaf_pkg::ByteWidth-1:0]           m_tdata,   // [7:0] text_byte
  output logic                                     m_tlast    // is_last
);

  logic             push_valid;
  logic             push_ready;
  sdaf_pkg::entry_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  sdaf_pkg::entry_t pop_data;

  sdaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sdaf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sdaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

@@ rtl/sdaf_front.sv @@
`default_nettype none
module sdaf_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic signed [sdaf_pkg::InWidth-1:0]  s_tdata,
  output logic                                      push_valid,
  input  wire logic                                 push_ready,
  output sdaf_pkg::entry_t                          push_data
);

  logic                    fv;
  sdaf_pkg::entry_t        fe;
  sdaf_pkg::entry_t        fe_next;
  logic [sdaf_pkg::InWidth-1:0] abs_val;

  // Two's complement magnitude fits 16 unsigned bits, even for the most negative value.
  always_comb begin
    abs_val = s_tdata[sdaf_pkg::InWidth-1] ? (~s_tdata + 16'd1) : s_tdata;
    fe_next.neg = s_tdata[sdaf_pkg::InWidth-1];
    if (abs_val > {2'b00, sdaf_pkg::MagLimit}) begin
      fe_next.mag = sdaf_pkg::MagLimit;
    end else begin
      fe_next.mag = abs_val[sdaf_pkg::MagWidth-1:0];
    end
  end

  assign s_tready   = !fv || push_ready;
  assign push_valid = fv;
  assign push_data  = fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      fe <= fe_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sdaf_fifo.sv @@
`default_nettype none
module sdaf_fifo #(
  parameter int unsigned DEPTH = sdaf_pkg::QueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire sdaf_pkg::entry_t  push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output sdaf_pkg::entry_t       pop_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sdaf_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sdaf_back.sv @@
`default_nettype none
`include "signed_decimal_ascii_formatter_core_macros.svh"
module sdaf_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            pop_valid,
  output logic                                 pop_ready,
  input  wire sdaf_pkg::entry_t                pop_data,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [sdaf_pkg::ByteWidth-1:0]       m_tdata,
  output logic                                 m_tlast
);

  sdaf_pkg::pos_t                   pos;
  sdaf_pkg::pos_t                   pos_next;
  logic [sdaf_pkg::MagWidth-1:0]    rem;
  logic [sdaf_pkg::MagWidth-1:0]    rem_next;
  logic [sdaf_pkg::ByteWidth-1:0]   byte_next;
  logic                             last_next;
  logic                             out_load;
  logic                             out_free;
  sdaf_pkg::digit_t                 dg;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    pos_next  = pos;
    rem_next  = rem;
    byte_next = sdaf_pkg::AsciiZero;
    last_next = 1'b0;
    out_load  = 1'b0;
    pop_ready = 1'b0;
    dg        = '0;
    if (out_free) begin
      unique case (pos)
        sdaf_pkg::POS_SIGN: begin
          if (pop_valid) begin
            pop_ready = 1'b1;
            out_load  = 1'b1;
            byte_next = pop_data.neg ? sdaf_pkg::AsciiMinus : sdaf_pkg::AsciiZero;
            rem_next  = pop_data.mag;
            pos_next  = sdaf_pkg::POS_THOU;
          end
        end
        sdaf_pkg::POS_THOU: begin
          dg        = sdaf_pkg::digit_step(rem, sdaf_pkg::ScaleThou);
          out_load  = 1'b1;
          byte_next = sdaf_pkg::AsciiZero + 8'(dg.digit);
          rem_next  = rem - dg.sub;
          pos_next  = sdaf_pkg::POS_HUND;
        end
        sdaf_pkg::POS_HUND: begin
          dg        = sdaf_pkg::digit_step(rem, sdaf_pkg::ScaleHund);
          out_load  = 1'b1;
          byte_next = sdaf_pkg::AsciiZero + 8'(dg.digit);
          rem_next  = rem - dg.sub;
          pos_next  = sdaf_pkg::POS_TENS;
        end
        sdaf_pkg::POS_TENS: begin
          dg        = sdaf_pkg::digit_step(rem, sdaf_pkg::ScaleTens);
          out_load  = 1'b1;
          byte_next = sdaf_pkg::AsciiZero + 8'(dg.digit);
          rem_next  = rem - dg.sub;
          pos_next  = sdaf_pkg::POS_UNITS;
        end
        sdaf_pkg::POS_UNITS: begin
          out_load  = 1'b1;
          byte_next = sdaf_pkg::AsciiZero + 8'(rem[3:0]);
          pos_next  = sdaf_pkg::POS_CR;
        end
        sdaf_pkg::POS_CR: begin
          out_load  = 1'b1;
          byte_next = sdaf_pkg::AsciiCr;
          last_next = 1'b1;
          pos_next  = sdaf_pkg::POS_SIGN;
        end
        default: begin
          pos_next = sdaf_pkg::POS_SIGN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= sdaf_pkg::POS_SIGN;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
  end

  // Output register: refill whenever the slot is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= byte_next;
      m_tlast <= last_next;
    end
  end

  `SDAF_ASSERT_NOW(a_last_is_cr, clk, rst, m_tvalid && m_tlast, m_tdata == sdaf_pkg::AsciiCr)
  `SDAF_ASSERT_NOW(a_rem_in_range, clk, rst, pos != sdaf_pkg::POS_SIGN,
                   rem <= sdaf_pkg::MagLimit)
  `SDAF_ASSERT_NOW(a_units_single_digit, clk, rst, pos == sdaf_pkg::POS_UNITS,
                   rem < sdaf_pkg::ScaleTens)
  `SDAF_ASSERT_NEXT(a_cr_closes_run, clk, rst, out_free && pos == sdaf_pkg::POS_CR,
                    pos == sdaf_pkg::POS_SIGN && m_tvalid && m_tlast)

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdaf_pkg::*;

  typedef struct {
    logic [ByteWidth-1:0] text_byte;
    logic                 is_last;
  } text_char_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InWidth-1:0]   s_tdata = '0;   // [15:0] signed_value
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [ByteWidth-1:0] m_tdata;        // [7:0] text_byte
  logic                 m_tlast;        // is_last

  logic [InWidth-1:0] pending_values[$];
  text_char_t         expected_chars[$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        total_items = 0;
  int unsigned        accepted_count = 0;

  // Saturation edges, zero, digit roll-overs and the most negative value.
  int directed_values[24] = '{0, 1, -1, 9, -9, 10, 99, 100, 999, 1000, 1234, -1234,
                              5678, -5678, 9999, -9999, 10000, -10000, 12345, 32767,
                              -32767, -32768, 21845, -21846};

  signed_decimal_ascii_formatter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle on about 30 percent of calls, except in one long stretch with no idling.
  function automatic bit roll_idle();
    if (cycle_count >= 1200 && cycle_count < 2400) return 1'b0;
    return $urandom_range(99) < 30;
  endfunction

  function automatic void format_value(input logic [InWidth-1:0] raw);
    logic        negative;
    int unsigned mag;
    int unsigned digits[4];
    text_char_t  c;
    negative = raw[InWidth-1];
    mag = negative ? 32'h10000 - int'(raw) : int'(raw);
    if (mag > int'(MagLimit)) mag = int'(MagLimit);
    digits[0] = mag / 1000;
    digits[1] = (mag / 100) % 10;
    digits[2] = (mag / 10) % 10;
    digits[3] = mag % 10;
    c.is_last   = 1'b0;
    c.text_byte = negative ? AsciiMinus : AsciiZero;
    expected_chars.push_back(c);
    for (int i = 0; i < 4; i++) begin
      c.text_byte = AsciiZero + ByteWidth'(digits[i]);
      expected_chars.push_back(c);
    end
    c.text_byte = AsciiCr;
    c.is_last   = 1'b1;
    expected_chars.push_back(c);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Driver: hold the item until accepted, then advance or idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_values.size() != 0 && !roll_idle()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_values.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: predict on input acceptance, check each output byte in order.
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        format_value(s_tdata);
        accepted_count++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want.text_byte)
            flag_mismatch($sformatf("text_byte %02h, want %02h", m_tdata, want.text_byte));
          if (m_tlast !== want.is_last)
            flag_mismatch($sformatf("is_last %0b, want %0b", m_tlast, want.is_last));
        end
      end
      m_tready <= !roll_idle();
    end
  end

  initial begin
    int pick;
    foreach (directed_values[i]) pending_values.push_back(InWidth'(directed_values[i]));
    repeat (440) begin
      pick = $urandom_range(99);
      if (pick < 55)
        pending_values.push_back(InWidth'(int'($urandom_range(19998)) - 9999));
      else if (pick < 70)
        pending_values.push_back(InWidth'(int'($urandom_range(198)) - 99));
      else
        pending_values.push_back(InWidth'($urandom));
    end
    total_items = pending_values.size();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Wait until every item is accepted and every predicted byte has been seen.
    while (accepted_count != total_items || expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/sdaf_pkg.sv
rtl/sdaf_front.sv
rtl/sdaf_fifo.sv
rtl/sdaf_back.sv
rtl/signed_decimal_ascii_formatter_core.sv
verif/tb_top.sv
